/* rtl/assert_macros.svh */
// Assertion macros used by the checker file lcse_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define LCSE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset.
`define LCSE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lcse_pkg.sv */
// Package for the layer colour special effects unit: codes, types, helpers.
// No dependencies.
`default_nettype none

package lcse_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BLEND_CONTROL = 2'd0;
    localparam logic [1:0] REG_FIRST_WEIGHT  = 2'd1;
    localparam logic [1:0] REG_SECOND_WEIGHT = 2'd2;
    localparam logic [1:0] REG_FADE_FACTOR   = 2'd3;

    // selected effect
    localparam logic [2:0] EFF_NONE   = 3'd0;
    localparam logic [2:0] EFF_BLEND  = 3'd1;
    localparam logic [2:0] EFF_BRIGHT = 3'd2;
    localparam logic [2:0] EFF_DARK   = 3'd3;
    localparam logic [2:0] EFF_B3D    = 3'd4;

    // datapath operation per channel
    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_SUM16 = 2'd1;
    localparam logic [1:0] KIND_SUM32 = 2'd2;
    localparam logic [1:0] KIND_DARK  = 2'd3;

    localparam logic [5:0] CHAN_MAX  = 6'd63;
    localparam logic [4:0] WEIGHT_ONE = 5'd16;
    localparam logic [7:0] FLAGS_FULL = 8'hFF;
    localparam logic [11:0] BIAS16   = 12'd8;
    localparam logic [11:0] BIAS32   = 12'd16;
    localparam logic [10:0] BIAS_DARK = 11'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] wa;
        logic [4:0] wb;
    } lcse_op_t;

    function automatic logic [4:0] sat16(input logic [4:0] v);
        sat16 = (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/lcse_chan.sv */
// One colour channel: registered products, then sum, scale and clamp.
// Depends on lcse_pkg.
`default_nettype none

module lcse_chan
    import lcse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       load,
    input  wire lcse_op_t   op,
    input  wire logic [5:0] a,
    input  wire logic [5:0] b,
    output logic      [5:0] res
);

    logic [10:0] pa_reg;
    logic [10:0] pb_reg;
    logic [1:0]  kind_reg;
    logic [11:0] sum;
    logic [10:0] dk;
    logic [7:0]  q16;
    logic [6:0]  q32;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pa_reg   <= 11'(a * op.wa);
            pb_reg   <= 11'(b * op.wb);
            kind_reg <= op.kind;
        end
    end

    always_comb
    begin
        sum = {1'b0, pa_reg} + {1'b0, pb_reg}
            + ((kind_reg == KIND_SUM32) ? BIAS32 : BIAS16);
        dk  = pb_reg + BIAS_DARK;
        q16 = sum[11:4];
        q32 = sum[11:5];
        unique case (kind_reg)
            KIND_SUM16: res = (q16 > 8'(CHAN_MAX)) ? CHAN_MAX : q16[5:0];
            KIND_SUM32: res = (q32 > 7'(CHAN_MAX)) ? CHAN_MAX : q32[5:0];
            KIND_DARK:  res = pa_reg[9:4] - dk[9:4];  // c - round-down fade
            KIND_PASS:  res = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/layer_color_special_effects_unit.sv */
// Top level of the layer colour special effects unit: decode, pipeline, config.
// Depends on lcse_pkg and lcse_chan.
//
//  channel   signals                                   direction
//  pixel     pix_valid/pix_stall, top_pixel,           request in
//            second_pixel, window_flags
//  result    res_valid/res_stall, result_pixel         request out
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data  write in
//
// Three register stages: effect decode, per-channel multiply, sum/clamp into
// the output register. One request per cycle sustained while res_stall is low.
// Each stage loads whenever the stage after it is empty or moving, so a
// stalled result holds in place while earlier empty slots still fill.
// Reset clears the valid bits and the configuration registers.
// cfg_ready is always high; writes take effect for the next decoded request.
`default_nettype none

module layer_color_special_effects_unit
    import lcse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pix_valid,
    output logic             pix_stall,
    input  wire logic [31:0] top_pixel,
    input  wire logic [31:0] second_pixel,
    input  wire logic [7:0]  window_flags,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic      [31:0] result_pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // configuration
    logic [15:0] blend_control_reg;
    logic [4:0]  first_weight_reg;
    logic [4:0]  second_weight_reg;
    logic [4:0]  fade_factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_control_reg <= '0;
            first_weight_reg  <= '0;
            second_weight_reg <= '0;
            fade_factor_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLEND_CONTROL: blend_control_reg <= cfg_data[15:0];
                REG_FIRST_WEIGHT:  first_weight_reg  <= cfg_data[4:0];
                REG_SECOND_WEIGHT: second_weight_reg <= cfg_data[4:0];
                REG_FADE_FACTOR:   fade_factor_reg   <= cfg_data[4:0];
            endcase
        end
    end

    // pipeline flow: a stage may load when it is empty or its request moves on
    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    assign r3 = !v3_reg || !res_stall;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign pix_stall = !r1;
    assign res_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= pix_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // stage 1: effect decode
    logic [7:0]  f1, f2;
    logic [15:0] tgt2;
    logic [7:0]  cls1;
    logic        hit2, sprite, three_d, sp_hit, td_hit, else_ok;
    logic [1:0]  mode;
    logic [2:0]  eff;
    lcse_op_t    op_next;
    logic [5:0]  a_next [3];
    logic [5:0]  b_next [3];
    logic [4:0]  eva;

    always_comb
    begin
        f1 = top_pixel[31:24];
        f2 = second_pixel[31:24];

        // second target class: sprite, then 3D, else the layer flags
        priority if (f2[7]) tgt2 = 16'h1000;
        else if (f2[6])     tgt2 = 16'h0100;
        else                tgt2 = {f2, 8'h00};
        hit2 = |(blend_control_reg & tgt2);

        sprite  = f1[7];
        three_d = f1[6];
        sp_hit  = sprite && hit2;
        td_hit  = three_d && hit2;

        priority if (sprite) cls1 = 8'h10;
        else if (three_d)    cls1 = 8'h01;
        else                 cls1 = f1;
        else_ok = (|(blend_control_reg[7:0] & cls1)) && window_flags[5];

        mode = blend_control_reg[7:6];
        priority if (sp_hit)    eff = EFF_BLEND;
        else if (td_hit)        eff = EFF_B3D;
        else if ({1'b0, mode} == EFF_BLEND)
                                eff = (else_ok && hit2) ? EFF_BLEND : EFF_NONE;
        else if ({1'b0, mode} != EFF_NONE)
                                eff = else_ok ? {1'b0, mode} : EFF_NONE;
        else                    eff = EFF_NONE;

        // sprite with 3D flag carries its own alpha
        eva = (sp_hit && three_d) ? sat16(f1[4:0]) : sat16(first_weight_reg);

        op_next = '{kind: KIND_PASS, wa: '0, wb: '0};
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = top_pixel[8*i +: 6];
            b_next[i] = second_pixel[8*i +: 6];
        end

        unique case (eff)
            EFF_BLEND:
            begin
                op_next.kind = KIND_SUM16;
                op_next.wa   = eva;
                op_next.wb   = (sp_hit && three_d) ? (WEIGHT_ONE - eva)
                                                   : sat16(second_weight_reg);
            end
            EFF_BRIGHT:
            begin
                // 16c + (63-c)f, rounded by 8, equals c + fade step
                op_next.kind = KIND_SUM16;
                op_next.wa   = WEIGHT_ONE;
                op_next.wb   = sat16(fade_factor_reg);
                for (int i = 0; i < 3; i++)
                    b_next[i] = CHAN_MAX - top_pixel[8*i +: 6];
            end
            EFF_DARK:
            begin
                op_next.kind = KIND_DARK;
                op_next.wa   = WEIGHT_ONE;
                op_next.wb   = sat16(fade_factor_reg);
                for (int i = 0; i < 3; i++)
                    b_next[i] = top_pixel[8*i +: 6];
            end
            EFF_B3D:
            begin
                // full alpha passes the top pixel untouched
                if (f1[4:0] != 5'h1F)
                begin
                    op_next.kind = KIND_SUM32;
                    op_next.wa   = f1[4:0] + 5'd1;
                    op_next.wb   = 5'h1F - f1[4:0];
                end
            end
            default: op_next.kind = KIND_PASS;
        endcase
    end

    lcse_op_t    op1_reg;
    logic [5:0]  a1_reg [3];
    logic [5:0]  b1_reg [3];
    logic [31:0] t1_reg, t2_reg;
    logic        pass2_reg;
    logic [31:0] result_reg;

    always_ff @(posedge clk)
    begin
        if (r1 && pix_valid)
        begin
            op1_reg <= op_next;
            a1_reg  <= a_next;
            b1_reg  <= b_next;
            t1_reg  <= top_pixel;
        end
        if (r2 && v1_reg)
        begin
            t2_reg    <= t1_reg;
            pass2_reg <= (op1_reg.kind == KIND_PASS);
        end
    end

    // stages 2 and 3: per-channel arithmetic
    logic [5:0] ch_res [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        lcse_chan u_chan (
            .clk  (clk),
            .load (r2 && v1_reg),
            .op   (op1_reg),
            .a    (a1_reg[g]),
            .b    (b1_reg[g]),
            .res  (ch_res[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
            result_reg <= pass2_reg ? t2_reg
                        : {FLAGS_FULL, 2'b00, ch_res[2], 2'b00, ch_res[1],
                           2'b00, ch_res[0]};
    end

    assign result_pixel = result_reg;

endmodule

`default_nettype wire

/* rtl/lcse_checker.sv */
// Port-level checker for the layer colour special effects unit, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lcse_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pix_valid,
    input wire logic        pix_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [31:0] result_pixel,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a free output slot always lets a new request in
    `LCSE_ASSERT_IMP(a_no_false_stall, clk, rst_n, !res_valid || !res_stall, !pix_stall, "pixel stalled with output free")

    // request accepted and the result side unstalled while it moves through the pipe: result must be showing
    `LCSE_ASSERT_NXT(a_latency, clk, rst_n, pix_valid && !pix_stall ##1 !res_stall ##1 !res_stall, res_valid, "result missing after three cycles")

    `LCSE_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(result_pixel), "stalled result changed")

    `LCSE_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config write refused")

endmodule

bind layer_color_special_effects_unit lcse_checker u_lcse_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for layer_color_special_effects_unit: directed and random pixels.
// Expected pixels come from a behavioural predictor kept in this file.
// Depends on lcse_pkg for register indexes and effect codes.
module testbench;
    import lcse_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;       // result-side hold-off for the pressure test
    localparam int DRAIN_CYCLES = 8;        // pipeline is three deep
    localparam int PHASE_ITEMS  = 100;

    // flag bits of a pixel word and the window byte
    localparam logic [7:0] FLAG_SPRITE = 8'h80;
    localparam logic [7:0] FLAG_3D     = 8'h40;
    localparam logic [7:0] WIN_EFFECTS = 8'h20;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        pix_valid    = 1'b0;
    logic [31:0] top_pixel    = '0;
    logic [31:0] second_pixel = '0;
    logic [7:0]  window_flags = '0;
    logic        res_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = REG_BLEND_CONTROL;
    logic [31:0] cfg_data     = '0;
    logic        pix_stall;
    logic        res_valid;
    logic [31:0] result_pixel;
    logic        cfg_ready;

    // shadow copy of the configuration registers
    logic [15:0] shadow_control = '0;
    logic [4:0]  shadow_first   = '0;
    logic [4:0]  shadow_second  = '0;
    logic [4:0]  shadow_fade    = '0;

    logic [31:0] pending_pixels[$];     // predicted pixels, oldest first
    logic [31:0] expected_pixel;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_en     = 1'b1;    // random gaps and stalls on both sides
    bit          hold_req    = 1'b0;    // asks the stall process for a long hold-off

    layer_color_special_effects_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .top_pixel    (top_pixel),
        .second_pixel (second_pixel),
        .window_flags (window_flags),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .result_pixel (result_pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Weights and sprite alpha above sixteen saturate to sixteen.
    function automatic int unsigned clamp_weight(input int unsigned v);
        return (v > 16) ? 16 : v;
    endfunction

    // Weighted sum of two 6-bit channels with rounding bias, clamped at 63.
    function automatic logic [5:0] mix_channel(input int unsigned a, input int unsigned b,
                                               input int unsigned wa, input int unsigned wb,
                                               input int unsigned bias, input int unsigned sh);
        int unsigned v;
        v = (a * wa + b * wb + bias) >> sh;
        return (v > 63) ? 6'd63 : v[5:0];
    endfunction

    // Brighten rounds with 8, darken with 7.
    function automatic logic [5:0] lift_channel(input int unsigned c, input int unsigned f);
        int unsigned v;
        v = c + ((((63 - c) * f + 8) >> 4) & 32'h3F);
        return v[5:0];
    endfunction

    function automatic logic [5:0] dim_channel(input int unsigned c, input int unsigned f);
        int unsigned v;
        v = c - (((c * f + 7) >> 4) & 32'h3F);
        return v[5:0];
    endfunction

    function automatic logic [31:0] predict_pixel(input logic [31:0] t, input logic [31:0] s,
                                                  input logic [7:0] w);
        logic [7:0]  f1;
        logic [7:0]  f2;
        logic [15:0] tgt2;
        logic [7:0]  cls1;
        logic        hit2;
        logic        sprite;
        logic        three_d;
        logic        sp_hit;
        logic        td_hit;
        logic        else_ok;
        logic [2:0]  mode;
        logic [2:0]  eff;
        int unsigned eva;
        int unsigned evb;
        int unsigned fct;
        logic [31:0] res;

        f1 = t[31:24];
        f2 = s[31:24];

        // class of the second pixel: sprite, 3D, else its own flags
        if (f2[7])
            tgt2 = 16'h1000;
        else if (f2[6])
            tgt2 = 16'h0100;
        else
            tgt2 = {f2, 8'h00};
        hit2 = (shadow_control & tgt2) != 0;

        sprite  = f1[7];
        three_d = f1[6];
        sp_hit  = sprite && hit2;
        td_hit  = three_d && hit2;

        if (sprite)
            cls1 = 8'h10;
        else if (three_d)
            cls1 = 8'h01;
        else
            cls1 = f1;
        else_ok = ((shadow_control & {8'h00, cls1}) != 0) && w[5];

        mode = {1'b0, shadow_control[7:6]};
        eff  = EFF_NONE;
        if (mode == EFF_BLEND)
            eff = (else_ok && hit2) ? EFF_BLEND : EFF_NONE;
        else if (mode != EFF_NONE)
            eff = else_ok ? mode : EFF_NONE;
        // sprite over a second target wins over 3D
        if (td_hit)
            eff = EFF_B3D;
        if (sp_hit)
            eff = EFF_BLEND;

        res = {FLAGS_FULL, 24'h000000};
        case (eff)
            EFF_BLEND:
            begin
                eva = clamp_weight(shadow_first);
                evb = clamp_weight(shadow_second);
                // sprite with 3D flag carries its own alpha
                if (sp_hit && three_d)
                begin
                    eva = clamp_weight(f1[4:0]);
                    evb = 16 - eva;
                end
                for (int k = 0; k < 3; k++)
                    res[8*k +: 6] = mix_channel(t[8*k +: 6], s[8*k +: 6], eva, evb, 8, 4);
            end
            EFF_BRIGHT:
            begin
                fct = clamp_weight(shadow_fade);
                for (int k = 0; k < 3; k++)
                    res[8*k +: 6] = lift_channel(t[8*k +: 6], fct);
            end
            EFF_DARK:
            begin
                fct = clamp_weight(shadow_fade);
                for (int k = 0; k < 3; k++)
                    res[8*k +: 6] = dim_channel(t[8*k +: 6], fct);
            end
            EFF_B3D:
            begin
                eva = f1[4:0] + 1;
                evb = 32 - eva;
                if (eva == 32)
                    res = t;    // full alpha: top pixel as it is
                else
                    for (int k = 0; k < 3; k++)
                        res[8*k +: 6] = mix_channel(t[8*k +: 6], s[8*k +: 6], eva, evb, 16, 5);
            end
            default:
                res = t;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("result with no request pending", result_pixel, 32'h0);
            else
            begin
                expected_pixel = pending_pixels.pop_front();
                if (result_pixel !== expected_pixel)
                    report_mismatch("result_pixel", result_pixel, expected_pixel);
            end
        end
    end

    // Result-side stalls: random bursts, or one long hold when asked.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall = 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                res_stall  = 1'b1;
            end
            else
                res_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one request; valid stays high afterwards unless a gap follows.
    task automatic send_pixel(input logic [31:0] t, input logic [31:0] s, input logic [7:0] w);
        logic [31:0] want;
        int          gap;
        want = predict_pixel(t, s, w);
        @(negedge clk);
        pix_valid    = 1'b1;
        top_pixel    = t;
        second_pixel = s;
        window_flags = w;
        do
            @(posedge clk);
        while (pix_stall);
        pending_pixels.push_back(want);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            pix_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drops valid and waits until every predicted pixel has come back.
    task automatic drain_pixels();
        @(negedge clk);
        pix_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BLEND_CONTROL: shadow_control = data[15:0];
            REG_FIRST_WEIGHT:  shadow_first   = data[4:0];
            REG_SECOND_WEIGHT: shadow_second  = data[4:0];
            REG_FADE_FACTOR:   shadow_fade    = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Writes all four registers once the pipe is empty; unused upper data bits are random.
    task automatic set_config(input logic [15:0] control, input logic [4:0] w1,
                              input logic [4:0] w2, input logic [4:0] fade);
        logic [31:0] data;
        drain_pixels();
        data = $urandom();
        data[15:0] = control;
        write_reg(REG_BLEND_CONTROL, data);
        data = $urandom();
        data[4:0] = w1;
        write_reg(REG_FIRST_WEIGHT, data);
        data = $urandom();
        data[4:0] = w2;
        write_reg(REG_SECOND_WEIGHT, data);
        data = $urandom();
        data[4:0] = fade;
        write_reg(REG_FADE_FACTOR, data);
    endtask

    function automatic logic [15:0] make_control(input logic [5:0] first_targets,
                                                 input logic [2:0] mode,
                                                 input logic [5:0] second_targets);
        return {2'b00, second_targets, mode[1:0], first_targets};
    endfunction

    // 0, 16, the saturating maximum, or anything in between
    function automatic logic [4:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return 5'd0;
            1: return WEIGHT_ONE;
            2: return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [15:0] random_control();
        logic [15:0] c;
        c = 16'($urandom_range(0, 65535));
        // half the time open every target so most pixels reach an effect
        if ($urandom_range(0, 1) == 0)
            c = c | 16'h3F3F;
        return c;
    endfunction

    // random word with channels pushed to the extremes now and then
    function automatic logic [31:0] random_pixel();
        logic [31:0] p;
        p = $urandom();
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 5))
                0: p[8*k +: 6] = 6'd0;
                1: p[8*k +: 6] = CHAN_MAX;
                default: ;
            endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // registers at reset select no effect: pixels pass through untouched
    task automatic test_reset_passthrough();
        send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF);
        send_pixel(32'h00000000, 32'h00000000, 8'h00);
    endtask

    task automatic test_alpha_blend();
        set_config(make_control(6'h3F, EFF_BLEND, 6'h3F), 5'd31, 5'd31, 5'd0);
        // plain top over plain second, weights saturate, sums clamp at 63
        send_pixel(32'h013F3F3F, 32'h013F3F3F, WIN_EFFECTS);
        // window closed: pass through
        send_pixel(32'h013F3F3F, 32'h013F3F3F, 8'h00);
        // sprite with 3D flag, own alpha above sixteen
        send_pixel({FLAG_SPRITE | FLAG_3D | 8'h1F, 24'h2A1503}, {FLAG_SPRITE, 24'h3F3F3F}, 8'h00);
        // sprite with 3D flag, alpha 5, second pixel of the 3D class
        send_pixel({FLAG_SPRITE | FLAG_3D | 8'h05, 24'h3F003F}, {FLAG_3D, 24'h003F00}, 8'h00);
        // plain sprite uses the weight registers
        send_pixel({FLAG_SPRITE, 24'hC0C0C0}, 32'h02111111, 8'h00);
        // 3D top at full alpha comes back unchanged, ignored bits included
        send_pixel({FLAG_3D | 8'h1F, 24'hEAD5C3}, {FLAG_SPRITE, 24'h3F3F3F}, 8'h00);
        // 3D top blended in 32 steps
        send_pixel({FLAG_3D | 8'h05, 24'h3F2010}, {FLAG_SPRITE, 24'h01203F}, 8'h00);
        // 3D top with no second target: blend mode needs the hit, so pass through
        send_pixel({FLAG_3D, 24'h123456}, 32'h00ABCDEF, WIN_EFFECTS);
    endtask

    task automatic test_brighten();
        set_config(make_control(6'h3F, EFF_BRIGHT, 6'h00), 5'd0, 5'd0, 5'd31);
        send_pixel(32'h01000000, 32'h00000000, WIN_EFFECTS);
        send_pixel(32'h013F3F3F, 32'h00000000, WIN_EFFECTS);
        send_pixel(32'h20EAD5C3, 32'hFFFFFFFF, WIN_EFFECTS | 8'hDF);
        send_pixel(32'h202A1503, 32'h00000000, 8'hDF);
        // sprite with no second target falls to the sprite class and brightens
        send_pixel({FLAG_SPRITE, 24'h102030}, 32'h00000000, WIN_EFFECTS);
    endtask

    task automatic test_darken();
        set_config(make_control(6'h3F, EFF_DARK, 6'h3F), 5'd0, 5'd0, WEIGHT_ONE);
        send_pixel(32'h083F3F3F, 32'h00000000, WIN_EFFECTS);
        send_pixel(32'h08000000, 32'h00000000, WIN_EFFECTS);
        send_pixel(32'h04C0FFC1, 32'h00000000, WIN_EFFECTS);
        // sprite over a second target is forced to the blend, weights zero
        send_pixel({FLAG_SPRITE, 24'h3F3F3F}, 32'h083F3F3F, WIN_EFFECTS);
    endtask

    task automatic test_random_phase(input logic [15:0] control, input int count);
        set_config(control, pick_weight(), pick_weight(), pick_weight());
        idle_en = ($urandom_range(0, 3) != 0);
        repeat (count)
            send_pixel(random_pixel(), random_pixel(), 8'($urandom_range(0, 255)));
    endtask

    // long result hold while requests keep coming: the pipe fills and stalls its input
    task automatic test_backpressure();
        set_config(random_control(), pick_weight(), pick_weight(), pick_weight());
        idle_en  = 1'b0;
        hold_req = 1'b1;
        repeat (40)
            send_pixel(random_pixel(), random_pixel(), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_no_idle_tail();
        set_config(random_control(), pick_weight(), pick_weight(), pick_weight());
        idle_en = 1'b0;
        repeat (PHASE_ITEMS)
            send_pixel(random_pixel(), random_pixel(), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_passthrough();
        test_alpha_blend();
        test_brighten();
        test_darken();
        test_random_phase(16'hFFFF, PHASE_ITEMS);
        test_random_phase(16'h0000, PHASE_ITEMS / 2);
        for (int i = 0; i < 7; i++)
            test_random_phase(random_control(), PHASE_ITEMS);
        test_backpressure();
        test_no_idle_tail();
        drain_pixels();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
